// ===== hw/rtl/obks_pkg.sv =====
package obks_pkg;

   localparam int MAX_ENTRIES_DEF = 64;

   // Operation codes of a request transaction.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Status codes of a response transaction.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MATCH   = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // Layout of the packed move word.
   localparam int SQ_W          = 3;
   localparam int TO_FILE_LSB   = 0;
   localparam int TO_ROW_LSB    = 3;
   localparam int FROM_FILE_LSB = 6;
   localparam int FROM_ROW_LSB  = 9;
   localparam int PROMO_LSB     = 12;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] entry_key;
      logic [15:0] packed_move;
      logic [15:0] entry_weight;
      logic [31:0] learn_word;
      logic [15:0] min_weight;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [SQ_W-1:0] from_file;
      logic [SQ_W-1:0] from_row;
      logic [SQ_W-1:0] to_file;
      logic [SQ_W-1:0] to_row;
      logic [SQ_W-1:0] promotion;
      logic [15:0]     match_weight;
      logic [31:0]     match_learn;
      logic            last;
   } rsp_type;

   // One stored book entry, 128 bits wide.
   typedef struct packed {
      logic [63:0] key;
      logic [15:0] move;
      logic [15:0] weight;
      logic [31:0] learn;
   } entry_type;

   // Enables of the entry memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   function automatic rsp_type plain_rsp(input logic [1:0] status);
      rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic rsp_type match_rsp(input entry_type e, input logic last);
      rsp_type r;
      r.status       = ST_MATCH;
      r.from_file    = e.move[FROM_FILE_LSB +: SQ_W];
      r.from_row     = e.move[FROM_ROW_LSB +: SQ_W];
      r.to_file      = e.move[TO_FILE_LSB +: SQ_W];
      r.to_row       = e.move[TO_ROW_LSB +: SQ_W];
      r.promotion    = e.move[PROMO_LSB +: SQ_W];
      r.match_weight = e.weight;
      r.match_learn  = e.learn;
      r.last         = last;
      return r;
   endfunction

endpackage

// ===== hw/rtl/obks_store.sv =====
module obks_store #(
   parameter int DEPTH = obks_pkg::MAX_ENTRIES_DEF,
   parameter int IDX_W = 6
) (
   input  logic                  clock,
   input  obks_pkg::mem_ctl_type mem_ctl,
   input  logic [IDX_W-1:0]      wr_addr,
   input  obks_pkg::entry_type   wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output obks_pkg::entry_type   rd_data
);

   obks_pkg::entry_type mem [DEPTH];
   obks_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds its value when no read is issued.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/obks_seq.sv =====
module obks_seq #(
   parameter int MAX_ENTRIES = obks_pkg::MAX_ENTRIES_DEF,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  obks_pkg::req_type     req_data,
   input  logic                  out_free,
   output logic                  push,
   output obks_pkg::rsp_type     push_data,
   output obks_pkg::mem_ctl_type mem_ctl,
   output logic [IDX_W-1:0]      wr_addr,
   output obks_pkg::entry_type   wr_data,
   output logic [IDX_W-1:0]      rd_addr,
   input  obks_pkg::entry_type   rd_data
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                dv_ff, dv_in;
   logic                pend_v_ff, pend_v_in;
   obks_pkg::entry_type pend_ff, pend_in;
   logic [63:0]         key_ff, key_in;
   logic [15:0]         min_ff, min_in;
   logic                hit;
   logic                blocked;

   assign hit = dv_ff && (rd_data.key == key_ff) && (rd_data.weight >= min_ff);
   // A second match cannot retire the held one while the output is busy.
   assign blocked = hit && pend_v_ff && !out_free;

   assign wr_addr = count_ff[IDX_W-1:0];
   assign rd_addr = issue_ff[IDX_W-1:0];
   assign wr_data = '{key: req_data.entry_key, move: req_data.packed_move,
                      weight: req_data.entry_weight, learn: req_data.learn_word};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      dv_in         = dv_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      key_in        = key_ff;
      min_in        = min_ff;
      push          = 1'b0;
      push_data     = obks_pkg::plain_rsp(obks_pkg::ST_DONE);
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      req_stall     = !((state_ff == S_IDLE) && out_free);
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               push = 1'b1;
               case (req_data.operation)
                  obks_pkg::OP_LOAD: begin
                     if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        push_data = obks_pkg::plain_rsp(obks_pkg::ST_FULL);
                     end
                  end
                  obks_pkg::OP_SEARCH: begin
                     push      = 1'b0;
                     state_in  = S_SCAN;
                     issue_in  = '0;
                     dv_in     = 1'b0;
                     pend_v_in = 1'b0;
                     key_in    = req_data.entry_key;
                     min_in    = req_data.min_weight;
                  end
                  obks_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!dv_ff && (issue_ff == count_ff)) begin
               // Every entry has been read and checked: flush the held match, or report no match.
               if (out_free) begin
                  push      = 1'b1;
                  push_data = pend_v_ff ? obks_pkg::match_rsp(pend_ff, 1'b1)
                                        : obks_pkg::plain_rsp(obks_pkg::ST_NOMATCH);
                  state_in  = S_IDLE;
               end
            end else if (!blocked) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     push      = 1'b1;
                     push_data = obks_pkg::match_rsp(pend_ff, 1'b0);
                  end
                  pend_in   = rd_data;
                  pend_v_in = 1'b1;
               end
               if (issue_ff < count_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  issue_in      = issue_ff + CNT_W'(1);
                  dv_in         = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         issue_ff  <= '0;
         dv_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issue_ff  <= issue_in;
         dv_ff     <= dv_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      key_ff  <= key_in;
      min_ff  <= min_in;
   end

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_ctl.wr_en)
      else $error("entry memory written during a search scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan read index beyond entry count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("response pushed into a busy output register");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |=> dv_ff)
      else $error("read data not flagged after a memory read");

endmodule

// ===== hw/rtl/opening_book_key_search.sv =====
// Channel    Direction  Valid / stall           Payload
// request    in         req_valid / req_stall   req_data  (obks_pkg::req_type)
// response   out        rsp_valid / rsp_stall   rsp_data  (obks_pkg::rsp_type)
//
// A load, a clear or an unused operation gives one transaction.
// A search reads the entries through the single read port of the entry memory, one entry
// a cycle while the scan is not paused, then checks the last read and flushes the held
// match or the no-match response.
// Reset is synchronous and empties the table; the memory contents themselves are not cleared.
// A response stall holds the output register and, once a further match is pending, pauses
// the scan; a new request is only taken while idle with room in the output register.
module opening_book_key_search #(
   parameter int MAX_ENTRIES = obks_pkg::MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  obks_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output obks_pkg::rsp_type rsp_data
);

   // The index needs at least one bit; the count must also hold the full depth.
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   obks_pkg::mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   obks_pkg::entry_type   wr_data;
   obks_pkg::entry_type   rd_data;
   logic                  out_free;
   logic                  push;
   obks_pkg::rsp_type     push_data;
   logic                  rsp_valid_ff, rsp_valid_in;
   obks_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // Writes happen only while idle and reads only while scanning, so the sequencer's
   // state machine is the interlock between the two memory ports.
   obks_store #(
      .DEPTH (MAX_ENTRIES),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   obks_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .push      (push),
      .push_data (push_data),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Output register: it takes a new transaction whenever the current one is
   // being accepted or there is none, so the scan waits only while a stalled transaction holds it.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = push ? push_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/book_response_check.sv =====
`timescale 1ns / 1ps

module book_response_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  obks_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  obks_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                requests_seen,
   output int                responses_seen,
   output int                matches_seen,
   output int                drops_seen,
   output int                longest_search
);

   // Shadow copy of the book held by the block.
   logic [63:0] book_key    [obks_pkg::MAX_ENTRIES_DEF];
   logic [15:0] stored_move [obks_pkg::MAX_ENTRIES_DEF];
   logic [15:0] book_weight [obks_pkg::MAX_ENTRIES_DEF];
   logic [31:0] book_learn  [obks_pkg::MAX_ENTRIES_DEF];
   int          book_count = 0;

   obks_pkg::rsp_type awaited_rsp [$];
   obks_pkg::rsp_type want;

   int mismatch_total  = 0;
   int request_total   = 0;
   int response_total  = 0;
   int match_total     = 0;
   int drop_total      = 0;
   int most_hits       = 0;

   function automatic obks_pkg::rsp_type status_only(input logic [1:0] status);
      obks_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   // Appends one predicted transaction at the tail of the queue.
   function automatic void add_awaited(input obks_pkg::rsp_type r);
      awaited_rsp.insert(awaited_rsp.size(), r);
   endfunction

   // Works out every response transaction that one request causes.
   task automatic predict_book(input obks_pkg::req_type item);
      obks_pkg::rsp_type r;
      int                idx;
      int                hits;
      int                emitted;
      hits    = 0;
      emitted = 0;
      case (item.operation)
         obks_pkg::OP_LOAD: begin
            if (book_count < obks_pkg::MAX_ENTRIES_DEF) begin
               book_key[book_count]    = item.entry_key;
               stored_move[book_count] = item.packed_move;
               book_weight[book_count] = item.entry_weight;
               book_learn[book_count]  = item.learn_word;
               book_count++;
               add_awaited(status_only(obks_pkg::ST_DONE));
            end else begin
               drop_total++;
               add_awaited(status_only(obks_pkg::ST_FULL));
            end
         end
         obks_pkg::OP_CLEAR: begin
            book_count = 0;
            add_awaited(status_only(obks_pkg::ST_DONE));
         end
         obks_pkg::OP_SEARCH: begin
            for (idx = 0; idx < book_count; idx++) begin
               if (book_key[idx] == item.entry_key && book_weight[idx] >= item.min_weight)
                  hits++;
            end
            for (idx = 0; idx < book_count; idx++) begin
               if (book_key[idx] == item.entry_key && book_weight[idx] >= item.min_weight)
               begin
                  emitted++;
                  r              = '0;
                  r.status       = obks_pkg::ST_MATCH;
                  r.from_file    = stored_move[idx][obks_pkg::FROM_FILE_LSB +: obks_pkg::SQ_W];
                  r.from_row     = stored_move[idx][obks_pkg::FROM_ROW_LSB +: obks_pkg::SQ_W];
                  r.to_file      = stored_move[idx][obks_pkg::TO_FILE_LSB +: obks_pkg::SQ_W];
                  r.to_row       = stored_move[idx][obks_pkg::TO_ROW_LSB +: obks_pkg::SQ_W];
                  r.promotion    = stored_move[idx][obks_pkg::PROMO_LSB +: obks_pkg::SQ_W];
                  r.match_weight = book_weight[idx];
                  r.match_learn  = book_learn[idx];
                  r.last         = (emitted == hits);
                  add_awaited(r);
               end
            end
            if (hits == 0)
               add_awaited(status_only(obks_pkg::ST_NOMATCH));
            match_total += hits;
            if (hits > most_hits)
               most_hits = hits;
         end
         default: begin
            add_awaited(status_only(obks_pkg::ST_DONE));
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] expected_value,
                              input logic [63:0] actual_value);
      if (actual_value !== expected_value) begin
         mismatch_total++;
         $display("%0t ns: response %0d, %s expected %0h, actual %0h",
                  $time, response_total, name, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         book_count = 0;
         awaited_rsp.delete();
      end else begin
         if (req_valid && !req_stall) begin
            request_total++;
            predict_book(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            response_total++;
            if (awaited_rsp.size() == 0) begin
               mismatch_total++;
               $display("%0t ns: response %0d, expected none, actual %h",
                        $time, response_total, rsp_data);
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("from_file", 64'(want.from_file), 64'(rsp_data.from_file));
               check_field("from_row", 64'(want.from_row), 64'(rsp_data.from_row));
               check_field("to_file", 64'(want.to_file), 64'(rsp_data.to_file));
               check_field("to_row", 64'(want.to_row), 64'(rsp_data.to_row));
               check_field("promotion", 64'(want.promotion), 64'(rsp_data.promotion));
               check_field("match_weight", 64'(want.match_weight),
                           64'(rsp_data.match_weight));
               check_field("match_learn", 64'(want.match_learn),
                           64'(rsp_data.match_learn));
               check_field("last", 64'(want.last), 64'(rsp_data.last));
            end
         end
      end
      fail_count     <= mismatch_total;
      pending        <= awaited_rsp.size();
      requests_seen  <= request_total;
      responses_seen <= response_total;
      matches_seen   <= match_total;
      drops_seen     <= drop_total;
      longest_search <= most_hits;
   end

endmodule

// ===== bench/opening_book_key_search_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the opening book key search block. A separate
// checker watches both channels, keeps its own copy of the book and compares
// every response transaction with what it predicts; this module only drives
// requests, wiggles the response stall and decides the outcome.
module opening_book_key_search_tb;

   // The block defines no name for operation code 3, which must behave as a
   // harmless no-op that leaves the table alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [63:0] KEY_A        = 64'h0123_4567_89AB_CDEF;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 80;
   localparam int          PHASE_ITEMS  = 88;
   localparam int          FILL_LOADS   = obks_pkg::MAX_ENTRIES_DEF + 2;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   obks_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   obks_pkg::rsp_type rsp_data;

   // Percentages of cycles in which the sender holds back and the receiver
   // stalls; each phase of the run sets its own pair.
   int idle_pct    = 0;
   int stall_pct   = 0;
   int cycle_count = 0;

   int fail_count;
   int pending;
   int requests_seen;
   int responses_seen;
   int matches_seen;
   int drops_seen;
   int longest_search;

   // A handful of keys per phase, so that searches actually find entries.
   logic [63:0] key_pool [4];

   always #2 clock = ~clock;

   opening_book_key_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   book_response_check response_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .requests_seen  (requests_seen),
      .responses_seen (responses_seen),
      .matches_seen   (matches_seen),
      .drops_seen     (drops_seen),
      .longest_search (longest_search)
   );

   // The receiver decides afresh every cycle whether to stall; with a zero
   // percentage it never does.
   always @(posedge clock) begin
      rsp_stall <= (int'($urandom_range(99)) < stall_pct);
   end

   // Safety net: a hung block must not keep the simulation running forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic obks_pkg::req_type make_req(input logic [1:0]  op,
                                                  input logic [63:0] key,
                                                  input logic [15:0] move,
                                                  input logic [15:0] weight,
                                                  input logic [31:0] learn,
                                                  input logic [15:0] least_weight);
      obks_pkg::req_type r;
      r.operation    = op;
      r.entry_key    = key;
      r.packed_move  = move;
      r.entry_weight = weight;
      r.learn_word   = learn;
      r.min_weight   = least_weight;
      return r;
   endfunction

   // Weights lean towards the two extremes now and then, so that the
   // comparison against the minimum is exercised at its edges.
   function automatic logic [15:0] pick_weight();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request transaction, after a random number of idle cycles,
   // and holds it steady until the block takes it. Valid is left high
   // afterwards, so back-to-back transactions never see it dip.
   task automatic send_request(input obks_pkg::req_type item);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender back until every predicted response has arrived. The
   // first edge lets the checker account for a transaction just accepted.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Empties the book and then loads past its capacity, so that the last
   // loads are refused and later searches run over a full table.
   task automatic fill_book(input bit single_key);
      int n;
      send_request(make_req(obks_pkg::OP_CLEAR, {$urandom, $urandom}, 16'($urandom), 16'h0,
                            $urandom, 16'h0));
      for (n = 0; n < FILL_LOADS; n++) begin
         send_request(make_req(obks_pkg::OP_LOAD,
                               single_key ? key_pool[0] : key_pool[$urandom_range(3)],
                               16'($urandom), pick_weight(), $urandom, pick_weight()));
      end
   endtask

   // Mostly loads and searches over the key pool; a few clears, unused
   // codes and searches for keys that were never stored act as noise.
   task automatic send_random_item();
      obks_pkg::req_type item;
      int unsigned       roll;
      item.entry_key    = key_pool[$urandom_range(3)];
      item.packed_move  = 16'($urandom);
      item.entry_weight = pick_weight();
      item.learn_word   = $urandom;
      item.min_weight   = pick_weight();
      roll = $urandom_range(99);
      if (roll < 2) begin
         item.operation = obks_pkg::OP_CLEAR;
      end else if (roll < 4) begin
         item.operation = OP_UNUSED;
      end else if (roll < 50) begin
         item.operation = obks_pkg::OP_LOAD;
      end else begin
         item.operation = obks_pkg::OP_SEARCH;
         if (roll >= 94)
            item.entry_key = {$urandom, $urandom};
      end
      send_request(item);
   endtask

   initial begin
      int phase;
      int n;
      int random_items;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The book starts empty, so a search must report no
      // match and the unused operation must do nothing at all.
      send_request(make_req(obks_pkg::OP_SEARCH, 64'h0, 16'h0, 16'h0, 32'h0, 16'h0));
      send_request(make_req(OP_UNUSED, 64'h0, 16'h0, 16'h0, 32'h0, 16'h0));
      // Entries at both extremes of every field, with two entries sharing
      // the all-ones key and two sharing an ordinary key.
      send_request(make_req(obks_pkg::OP_LOAD, '1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0));
      send_request(make_req(obks_pkg::OP_LOAD, 64'h0, 16'h0000, 16'h0000, 32'h0000_0000,
                            16'hFFFF));
      send_request(make_req(obks_pkg::OP_LOAD, '1, 16'h7FFF, 16'h0000, 32'h8000_0001, 16'h0));
      // The move with only its top bit set must unpack to all zero squares.
      send_request(make_req(obks_pkg::OP_LOAD, KEY_A, 16'h8000, 16'd100, 32'h1234_5678,
                            16'h0));
      send_request(make_req(obks_pkg::OP_LOAD, KEY_A, 16'h5A5A, 16'd99, 32'hFFFF_0000,
                            16'h0));
      // Searches in which the minimum weight admits all, some or none.
      send_request(make_req(obks_pkg::OP_SEARCH, '1, 16'h0, 16'h0, 32'h0, 16'h0000));
      send_request(make_req(obks_pkg::OP_SEARCH, '1, 16'h0, 16'h0, 32'h0, 16'hFFFF));
      send_request(make_req(obks_pkg::OP_SEARCH, 64'h0, 16'h0, 16'h0, 32'h0, 16'h0000));
      send_request(make_req(obks_pkg::OP_SEARCH, 64'h0, 16'h0, 16'h0, 32'h0, 16'h0001));
      send_request(make_req(obks_pkg::OP_SEARCH, KEY_A, 16'h0, 16'h0, 32'h0, 16'd100));
      send_request(make_req(obks_pkg::OP_SEARCH, KEY_A, 16'h0, 16'h0, 32'h0, 16'h0000));
      // A key differing in a single bit must not match.
      send_request(make_req(obks_pkg::OP_SEARCH, KEY_A ^ 64'h8000_0000_0000_0000, 16'h0,
                            16'h0, 32'h0, 16'h0));
      // The unused code carrying load-like fields must not store anything.
      send_request(make_req(OP_UNUSED, KEY_A, 16'hA5A5, 16'hFFFF, 32'hDEAD_BEEF, 16'h0));
      send_request(make_req(obks_pkg::OP_SEARCH, KEY_A, 16'h0, 16'h0, 32'h0, 16'h0000));
      // After a clear the old entries are gone and loading starts afresh.
      send_request(make_req(obks_pkg::OP_CLEAR, '1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                            16'hFFFF));
      send_request(make_req(obks_pkg::OP_SEARCH, '1, 16'h0, 16'h0, 32'h0, 16'h0000));
      send_request(make_req(obks_pkg::OP_LOAD, KEY_A, 16'hA5A5, 16'd7, 32'h0F0F_0F0F, 16'h0));
      send_request(make_req(obks_pkg::OP_SEARCH, KEY_A, 16'h0, 16'h0, 32'h0, 16'h0000));
      wait_drained();

      // Random part in four phases: a free-flowing one, a starved sender, a
      // stalling receiver and both at once. The second and fourth phases
      // begin by filling the book to overflow, once with a single key so
      // that one search can return a full table of matches.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 80;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 80;
            end
            default: begin
               idle_pct  = 38;
               stall_pct = 38;
            end
         endcase
         for (n = 0; n < 4; n++)
            key_pool[n] = {$urandom, $urandom};
         random_items = PHASE_ITEMS;
         if (phase == 1 || phase == 3) begin
            fill_book(phase == 1);
            random_items = PHASE_ITEMS - FILL_LOADS;
         end
         for (n = 0; n < random_items; n++)
            send_random_item();
         // The sender pauses here until the book has answered everything.
         wait_drained();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d responses, %0d of them matches.",
               requests_seen, responses_seen, matches_seen);
      $display("Loads refused on a full book: %0d; most matches from one search: %0d.",
               drops_seen, longest_search);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
